// ----- rtl/adx_pkg.sv -----
// Shared constants, types and register codes for the Adamax moment update block.
// No dependencies; every module of the block, and the testbench, imports this package.
package adx_pkg;

	localparam int ENTRIES    = 256;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_BETA_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA_NORM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd2;

	localparam logic [15:0] BETA_FIRST_RST = 16'd58982;
	localparam logic [15:0] BETA_NORM_RST  = 16'd65471;
	localparam logic [23:0] STEP_SIZE_RST  = 24'd655;

	// eps * |m| is 24 x 32 bits; the divider resolves one quotient bit per stage
	localparam int DIVD_W     = 56;
	localparam int DIV_STAGES = DIVD_W;
	localparam int RES_W      = DIVD_W + 2;
	// side data through the divider: {negative, zero norm, position}
	localparam int SIDE_W     = 34;

	localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] mom_x;
		logic signed [31:0] mom_z;
		logic [31:0]        nrm_x;
		logic [31:0]        nrm_z;
	} entry_state_t;

	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		entry_state_t       data;
	} ram_wr_t;

endpackage

// ----- rtl/adx_in_if.sv -----
// Input channel: entry index, gradient and position of one point.
// Standalone; valid/ready handshake.
interface adx_in_if;
	logic               valid;
	logic               ready;
	logic [7:0]         entry_index;
	logic signed [31:0] grad_x;
	logic signed [31:0] grad_z;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_z;

	modport source (output valid, entry_index, grad_x, grad_z, pos_x, pos_z, input ready);
	modport sink   (input valid, entry_index, grad_x, grad_z, pos_x, pos_z, output ready);
endinterface

// ----- rtl/adx_out_if.sv -----
// Result channel: updated position and saturation flag.
// Standalone; valid/ready handshake.
interface adx_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_pos_x;
	logic signed [31:0] new_pos_z;
	logic               saturated;

	modport source (output valid, new_pos_x, new_pos_z, saturated, input ready);
	modport sink   (input valid, new_pos_x, new_pos_z, saturated, output ready);
endinterface

// ----- rtl/adamax_momentum_update.sv -----
// Adamax moment update: top level. Depends on adx_pkg, adx_in_if, adx_out_if,
// adx_state_ram, adx_moment_unit and adx_div_pipe.
// The output register holds each result until it is taken.
// Throughput: one transaction per cycle for differing entries while the output is not stalled; an
// entry already held in the read or update stage blocks a new one for the same entry until written back.
// The 56-stage divider (one quotient bit per stage) makes up most of the pipeline.
// Reset: all moment and norm entries read as zero, registers return to their defaults.
module adamax_momentum_update (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [adx_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [adx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	adx_in_if.sink                          items,
	adx_out_if.source                       results
);
	import adx_pkg::*;

	// configuration
	logic [15:0] beta_first_q;
	logic [15:0] beta_norm_q;
	logic [23:0] step_size_q;

	// pipeline control
	logic adv;
	logic hazard;
	logic acc;
	logic v_last;
	logic out_load;
	logic [IDX_W-1:0] idx;

	// stage 1: read data returning from the store
	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic signed [31:0] gx_s1, gz_s1, px_s1, pz_s1;
	entry_state_t       rd_data;

	// stage 2: products registered in the moment units, write-back here
	logic               v_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic signed [31:0] px_s2, pz_s2;
	logic signed [31:0] mx_new, mz_new;
	logic [31:0]        ux_new, uz_new;
	ram_wr_t            wr;

	// stage 3: magnitudes for the step product
	logic               v_s3;
	logic [31:0]        mabs_x_s3, mabs_z_s3, ux_s3, uz_s3;
	logic               neg_x_s3, neg_z_s3;
	logic signed [31:0] px_s3, pz_s3;

	// stage 4: divider operands
	logic               v_s4;
	logic [DIVD_W-1:0]  prod_x_s4, prod_z_s4;
	logic [31:0]        ux_s4, uz_s4;
	logic [SIDE_W-1:0]  side_x_s4, side_z_s4;

	// divider outputs
	logic               dv_x, dv_z;
	logic [DIVD_W-1:0]  quo_x, quo_z;
	logic [SIDE_W-1:0]  side_x, side_z;

	// final subtract and clamp
	logic [RES_W-1:0]   qs_x, qs_z, res_x, res_z;
	logic               sat_x, sat_z;
	logic signed [31:0] val_x, val_z;

	// output register
	logic               out_valid_q;
	logic signed [31:0] out_x_q, out_z_q;
	logic               out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_first_q <= BETA_FIRST_RST;
			beta_norm_q  <= BETA_NORM_RST;
			step_size_q  <= STEP_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BETA_FIRST: beta_first_q <= cfg_wdata[15:0];
				CFG_BETA_NORM:  beta_norm_q  <= cfg_wdata[15:0];
				CFG_STEP_SIZE:  step_size_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The pipeline moves unless a finished result sits in the last divider stage and the
	// output register cannot take it; every stage then holds, bubbles ahead of it included.
	assign v_last   = dv_x & dv_z;
	assign out_load = !out_valid_q || results.ready;
	assign adv      = !v_last || out_load;

	// Read-modify-write interlock: the entry in stage 1 or 2 has not been written back yet.
	assign idx         = items.entry_index[IDX_W-1:0];
	assign hazard      = (v_s1 && (idx_s1 == idx)) || (v_s2 && (idx_s2 == idx));
	assign items.ready = adv && !hazard;
	assign acc         = items.valid && items.ready;

	adx_state_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (idx),
		.rd_data (rd_data),
		.wr      (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= idx;
			gx_s1  <= items.grad_x;
			gz_s1  <= items.grad_z;
			px_s1  <= items.pos_x;
			pz_s1  <= items.pos_z;

			idx_s2 <= idx_s1;
			px_s2  <= px_s1;
			pz_s2  <= pz_s1;
		end
	end

	adx_moment_unit u_mom_x (
		.clk        (clk),
		.en         (adv),
		.beta_first (beta_first_q),
		.beta_norm  (beta_norm_q),
		.mom        (rd_data.mom_x),
		.nrm        (rd_data.nrm_x),
		.grad       (gx_s1),
		.mom_new    (mx_new),
		.nrm_new    (ux_new)
	);

	adx_moment_unit u_mom_z (
		.clk        (clk),
		.en         (adv),
		.beta_first (beta_first_q),
		.beta_norm  (beta_norm_q),
		.mom        (rd_data.mom_z),
		.nrm        (rd_data.nrm_z),
		.grad       (gz_s1),
		.mom_new    (mz_new),
		.nrm_new    (uz_new)
	);

	// write-back once, as stage 2 hands on
	assign wr.en         = adv && v_s2;
	assign wr.addr       = idx_s2;
	assign wr.data.mom_x = mx_new;
	assign wr.data.mom_z = mz_new;
	assign wr.data.nrm_x = ux_new;
	assign wr.data.nrm_z = uz_new;

	always_ff @(posedge clk) begin
		if (adv) begin
			mabs_x_s3 <= mx_new[31] ? (~mx_new + 32'd1) : mx_new;
			mabs_z_s3 <= mz_new[31] ? (~mz_new + 32'd1) : mz_new;
			neg_x_s3  <= mx_new[31];
			neg_z_s3  <= mz_new[31];
			ux_s3     <= ux_new;
			uz_s3     <= uz_new;
			px_s3     <= px_s2;
			pz_s3     <= pz_s2;

			prod_x_s4 <= DIVD_W'(step_size_q) * DIVD_W'(mabs_x_s3);
			prod_z_s4 <= DIVD_W'(step_size_q) * DIVD_W'(mabs_z_s3);
			ux_s4     <= ux_s3;
			uz_s4     <= uz_s3;
			side_x_s4 <= {neg_x_s3, ux_s3 == 32'd0, px_s3};
			side_z_s4 <= {neg_z_s3, uz_s3 == 32'd0, pz_s3};
		end
	end

	adx_div_pipe u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s4),
		.dividend  (prod_x_s4),
		.divisor   (ux_s4),
		.side_in   (side_x_s4),
		.out_valid (dv_x),
		.quotient  (quo_x),
		.side_out  (side_x)
	);

	adx_div_pipe u_div_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s4),
		.dividend  (prod_z_s4),
		.divisor   (uz_s4),
		.side_in   (side_z_s4),
		.out_valid (dv_z),
		.quotient  (quo_z),
		.side_out  (side_z)
	);

	// side data: [33] moment negative, [32] zero norm (quotient forced to 0), [31:0] position
	always_comb begin
		if (side_x[32]) begin
			qs_x = '0;
		end else if (side_x[33]) begin
			qs_x = -{2'b00, quo_x};
		end else begin
			qs_x = {2'b00, quo_x};
		end
		if (side_z[32]) begin
			qs_z = '0;
		end else if (side_z[33]) begin
			qs_z = -{2'b00, quo_z};
		end else begin
			qs_z = {2'b00, quo_z};
		end
	end

	assign res_x = {{(RES_W-32){side_x[31]}}, side_x[31:0]} - qs_x;
	assign res_z = {{(RES_W-32){side_z[31]}}, side_z[31:0]} - qs_z;
	assign sat_x = !((&res_x[RES_W-1:31]) || (~|res_x[RES_W-1:31]));
	assign sat_z = !((&res_z[RES_W-1:31]) || (~|res_z[RES_W-1:31]));
	assign val_x = sat_x ? (res_x[RES_W-1] ? POS_MIN : POS_MAX) : res_x[31:0];
	assign val_z = sat_z ? (res_z[RES_W-1] ? POS_MIN : POS_MAX) : res_z[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= v_last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q   <= val_x;
			out_z_q   <= val_z;
			out_sat_q <= sat_x || sat_z;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.new_pos_x = out_x_q;
	assign results.new_pos_z = out_z_q;
	assign results.saturated = out_sat_q;

endmodule

// ----- rtl/adx_state_ram.sv -----
// Per-entry moment/norm store: one write port, one registered read port.
// Depends on adx_pkg. Per-entry valid bits make never-written entries read as zero.
module adx_state_ram (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [adx_pkg::IDX_W-1:0]  rd_addr,
	output adx_pkg::entry_state_t      rd_data,
	input  adx_pkg::ram_wr_t           wr
);
	import adx_pkg::*;

	entry_state_t       mem [ENTRIES];
	entry_state_t       rd_q;
	logic               rd_vld_q;
	logic [ENTRIES-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ----- rtl/adx_moment_unit.sv -----
// One component's moment and infinity-norm update: products registered, then
// round, clamp and max. Depends on adx_pkg.
module adx_moment_unit (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        beta_first,
	input  logic [15:0]        beta_norm,
	input  logic signed [31:0] mom,
	input  logic [31:0]        nrm,
	input  logic signed [31:0] grad,
	output logic signed [31:0] mom_new,
	output logic [31:0]        nrm_new
);
	import adx_pkg::*;

	logic [16:0]        b1_comp;
	logic [31:0]        grad_abs;
	logic signed [48:0] pm_s2;
	logic signed [49:0] pg_s2;
	logic [47:0]        pu_s2;
	logic [31:0]        ag_s2;
	logic signed [50:0] sum;
	logic signed [34:0] fl;
	logic [31:0]        nrm_dec;

	assign b1_comp  = 17'h10000 - {1'b0, beta_first};
	assign grad_abs = grad[31] ? (~grad + 32'd1) : grad;

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s2 <= $signed({1'b0, beta_first}) * mom;
			pg_s2 <= $signed({1'b0, b1_comp}) * grad;
			pu_s2 <= beta_norm * nrm;
			ag_s2 <= grad_abs;
		end
	end

	// round half up, then floor: upper bits of the sum
	assign sum = 51'(pm_s2) + 51'(pg_s2) + 51'sd32768;
	assign fl  = sum[50:16];

	always_comb begin
		if ((&fl[34:31]) || (~|fl[34:31])) begin
			mom_new = fl[31:0];
		end else begin
			mom_new = fl[34] ? POS_MIN : POS_MAX;
		end
	end

	assign nrm_dec = pu_s2[47:16];
	assign nrm_new = (ag_s2 > nrm_dec) ? ag_s2 : nrm_dec;

endmodule

// ----- rtl/adx_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on adx_pkg.
module adx_div_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [adx_pkg::DIVD_W-1:0]  dividend,
	input  logic [31:0]                 divisor,
	input  logic [adx_pkg::SIDE_W-1:0]  side_in,
	output logic                        out_valid,
	output logic [adx_pkg::DIVD_W-1:0]  quotient,
	output logic [adx_pkg::SIDE_W-1:0]  side_out
);
	import adx_pkg::*;

	logic [31:0]        rem [DIV_STAGES+1];
	logic [DIVD_W-1:0]  dq  [DIV_STAGES+1];
	logic [31:0]        dvs [DIV_STAGES+1];
	logic [SIDE_W-1:0]  sd  [DIV_STAGES+1];
	logic               vld [DIV_STAGES+1];

	assign rem[0] = '0;
	assign dq[0]  = dividend;
	assign dvs[0] = divisor;
	assign sd[0]  = side_in;
	assign vld[0] = in_valid;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [32:0] trial;
		logic [32:0] diff;
		logic        ge;

		// dividend shifts out at the top, quotient bits shift in at the bottom
		assign trial = {rem[k], dq[k][DIVD_W-1]};
		assign diff  = trial - {1'b0, dvs[k]};
		assign ge    = trial >= {1'b0, dvs[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[k+1] <= ge ? diff[31:0] : trial[31:0];
				dq[k+1]  <= {dq[k][DIVD_W-2:0], ge};
				dvs[k+1] <= dvs[k];
				sd[k+1]  <= sd[k];
			end
		end
	end

	assign out_valid = vld[DIV_STAGES];
	assign quotient  = dq[DIV_STAGES];
	assign side_out  = sd[DIV_STAGES];

endmodule

// ----- rtl/adx_checker.sv -----
// Port-level checks for adamax_momentum_update, bound to the top level.
// Depends on adx_pkg.
module adx_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [7:0]         in_entry,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_z,
	input logic               out_sat
);
	import adx_pkg::*;

	// no result while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// stalled transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_z)
		&& $stable(out_sat))
		else $error("stalled result changed");

	// same entry cannot follow directly: its update is not written back yet
	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !(in_valid && in_ready && in_entry == $past(in_entry)))
		else $error("same entry accepted on consecutive cycles");

	// a clamp leaves at least one component at a limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_sat |-> out_x == POS_MAX || out_x == POS_MIN
		|| out_z == POS_MAX || out_z == POS_MIN)
		else $error("saturation flag without clamped value");

endmodule

bind adamax_momentum_update adx_checker u_adx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_entry  (items.entry_index),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_x     (results.new_pos_x),
	.out_z     (results.new_pos_z),
	.out_sat   (results.saturated)
);

// ----- verif/adx_in_if.sv -----
// Channel interfaces for the testbench: none are declared here.
// The testbench compiles against rtl/adx_in_if.sv and rtl/adx_out_if.sv.

// ----- verif/tb.sv -----
// Testbench for adamax_momentum_update: directed and random point updates, results checked
// against an Adamax predictor held in a small scoreboard class. Depends on adx_pkg, the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import adx_pkg::*;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] pz;
		logic               sat;
	} pos_res_t;

	// Adamax predictor and queue of expected positions
	class adamax_board;
		logic [15:0]        b1, b2;
		logic [23:0]        eps;
		logic signed [31:0] mom[2][ENTRIES];
		logic [31:0]        nrm[2][ENTRIES];
		pos_res_t           pending[$];
		int                 errors;

		function void clear();
			b1 = BETA_FIRST_RST;
			b2 = BETA_NORM_RST;
			eps = STEP_SIZE_RST;
			errors = 0;
			foreach (mom[c, i]) begin
				mom[c][i] = '0;
				nrm[c][i] = '0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_BETA_FIRST: begin
					b1 = d[15:0];
				end
				CFG_BETA_NORM: begin
					b2 = d[15:0];
				end
				CFG_STEP_SIZE: begin
					eps = d;
				end
				default: ;
			endcase
		endfunction

		// one component: moment, norm, quotient, clamped position
		function longint step_axis(int c, int e, longint g, longint p, ref bit sat);
			longint s, m, ag, q;
			longint unsigned u, am, mag;
			s = longint'(b1) * longint'(mom[c][e]) + (65536 - longint'(b1)) * g + 32768;
			m = s >>> 16;	// arithmetic shift is floor
			if (m > 64'sd2147483647) m = 64'sd2147483647;
			if (m < -64'sd2147483648) m = -64'sd2147483648;
			mom[c][e] = m[31:0];
			ag = (g < 0) ? -g : g;
			u = (longint'(b2) * longint'(nrm[c][e])) >> 16;
			if (ag > u) u = ag;
			nrm[c][e] = u[31:0];
			q = 0;
			if (u != 0) begin
				am = (m < 0) ? -m : m;
				mag = (longint'(eps) * am) / u;
				q = (m < 0) ? -longint'(mag) : longint'(mag);
			end
			p = p - q;
			if (p > 64'sd2147483647) begin
				sat = 1;
				p = 64'sd2147483647;
			end else if (p < -64'sd2147483648) begin
				sat = 1;
				p = -64'sd2147483648;
			end
			return p;
		endfunction

		function void note_item(logic [7:0] idx, logic signed [31:0] gx, logic signed [31:0] gz,
				logic signed [31:0] px, logic signed [31:0] pz);
			pos_res_t r;
			bit       sat;
			longint   nx, nz;
			sat = 0;
			nx = step_axis(0, idx % ENTRIES, gx, px, sat);
			nz = step_axis(1, idx % ENTRIES, gz, pz, sat);
			r.px = nx[31:0];
			r.pz = nz[31:0];
			r.sat = sat;
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [31:0] px, logic signed [31:0] pz, logic sat);
			pos_res_t r;
			if (pending.size() == 0) begin
				$display("%t unexpected transaction: x %h z %h sat %b", $time, px, pz, sat);
				errors++;
				return;
			end
			r = pending.pop_front();
			if (px !== r.px || pz !== r.pz || sat !== r.sat) begin
				$display("%t mismatch: expected x %h z %h sat %b, actual x %h z %h sat %b",
					$time, r.px, r.pz, r.sat, px, pz, sat);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 1;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int                    send_idle = 0;	// percent of cycles the sender holds off
	int                    recv_idle = 0;	// percent of cycles the receiver stalls

	adx_in_if  items ();
	adx_out_if results ();

	adamax_momentum_update u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .items(items.sink), .results(results.source)
	);

	adamax_board board = new();

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		items.valid = 0;
		items.entry_index = '0;
		items.grad_x = '0;
		items.grad_z = '0;
		items.pos_x = '0;
		items.pos_z = '0;
		results.ready = 0;
	end

	// receiver: random stall, checks on every accepted transaction
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready)
			board.check_result(results.new_pos_x, results.new_pos_z, results.saturated);
		results.ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 0;
		board.write_reg(idx, d);
		@(posedge clk);
	endtask

	// offers one transaction and waits for its acceptance; valid stays high across items unless the sender holds off
	task automatic send_item(logic [7:0] idx, logic [31:0] gx, logic [31:0] gz,
			logic [31:0] px, logic [31:0] pz);
		while ($urandom_range(99) < send_idle) begin
			items.valid <= 0;
			@(posedge clk);
		end
		items.valid <= 1;
		items.entry_index <= idx;
		items.grad_x <= gx;
		items.grad_z <= gz;
		items.pos_x <= px;
		items.pos_z <= pz;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		board.note_item(idx, gx, gz, px, pz);
	endtask

	task automatic drain();
		items.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	// mostly moderate gradients on a handful of entries so moments build up
	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			2: return $urandom_range(3);
			default: return {{12{$urandom_range(1) ? 1'b1 : 1'b0}}, 20'($urandom())};
		endcase
	endfunction

	task automatic random_items(int n);
		logic [7:0] idx;
		repeat (n) begin
			idx = $urandom_range(3) == 0 ? 8'($urandom()) : 8'($urandom_range(7));
			send_item(idx, rand_word(), rand_word(), rand_word(), rand_word());
		end
	endtask

	initial begin
		arst_n <= 0;
		board.clear();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero norm, extreme gradients and positions, saturation, index extremes
		send_item(8'd0, 32'd0, 32'd0, 32'h1234_5678, 32'h8000_0000);
		send_item(8'd255, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_item(8'd255, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_item(8'd1, 32'hffff_ffff, 32'd1, 32'd0, 32'd0);
		send_item(8'd1, 32'hffff_ffff, 32'd1, 32'h7fff_fff0, 32'h8000_0010);
		send_item(8'd255, 32'd0, 32'd0, 32'h8000_0000, 32'h7fff_ffff);
		drain();
		write_reg(CFG_STEP_SIZE, 24'hff_ffff);
		write_reg(CFG_BETA_FIRST, 16'd0);
		write_reg(CFG_BETA_NORM, 16'hffff);
		write_reg(2'd3, 24'h12_3456);	// unused index, ignored
		send_item(8'd2, 32'h0001_0000, 32'hffff_0000, 32'h7fff_0000, 32'h8001_0000);
		send_item(8'd2, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_item(8'd3, 32'h0000_0001, 32'h8000_0000, 32'd0, 32'd0);
		drain();
		write_reg(CFG_BETA_FIRST, 16'hffff);
		write_reg(CFG_BETA_NORM, 16'd0);
		write_reg(CFG_STEP_SIZE, 24'd0);
		send_item(8'd2, 32'h0003_0000, 32'hfffd_0000, 32'h0000_1000, 32'h0000_2000);
		send_item(8'd4, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		drain();

		// random phases, idling pattern changing, register settings varied
		send_idle = 30; recv_idle = 49;
		write_reg(CFG_BETA_FIRST, 16'd58982);
		write_reg(CFG_BETA_NORM, 16'd65471);
		write_reg(CFG_STEP_SIZE, 24'd655);
		random_items(600);
		drain();
		send_idle = 49; recv_idle = 30;
		write_reg(CFG_BETA_FIRST, 16'($urandom()));
		write_reg(CFG_BETA_NORM, 16'($urandom()));
		write_reg(CFG_STEP_SIZE, 24'($urandom()));
		random_items(600);
		drain();
		send_idle = 0; recv_idle = 0;
		write_reg(CFG_BETA_FIRST, 16'd32768);
		write_reg(CFG_BETA_NORM, 16'hffff);
		write_reg(CFG_STEP_SIZE, 24'h01_0000);
		random_items(600);
		drain();

		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
